[src/hohmann_transfer_delta_v_macros.svh]
// ----------------------------------------------------------------------------
// Hohmann transfer delta-v: assertion macros
// Concurrent checks used by the top level; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HOHMANN_TRANSFER_DELTA_V_MACROS_SVH
`define HOHMANN_TRANSFER_DELTA_V_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define HTDV_ASSERT_IMPLIES(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("htdv: same-cycle check failed");
// next-cycle implication
`define HTDV_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("htdv: next-cycle check failed");
`else
`define HTDV_ASSERT_IMPLIES(name, clk_s, rst_s, ante, cons)
`define HTDV_ASSERT_NEXT(name, clk_s, rst_s, ante, cons)
`endif
`endif

[src/htdv_pkg.sv]
// ----------------------------------------------------------------------------
// htdv_pkg
// Shared widths, constants and helpers of the Hohmann delta-v pipeline.
// ----------------------------------------------------------------------------
package htdv_pkg;

  localparam int RADIUS_BITS  = 20;
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 18;

  localparam int MU_W   = 48;
  localparam int OUT_W  = 32;
  localparam logic [MU_W-1:0] MU_RESET = 48'd102041713;
  localparam logic [27:0] FIVE_POW_12 = 28'd244140625;

  // mu * 5^12 and the scaled base B = that << 16
  localparam int BM_W   = 76;
  localparam int BASE_W = BM_W + 16;
  localparam int PP_W   = 26 + RADIUS_BITS;
  localparam int PR_W   = BM_W + RADIUS_BITS;
  localparam int NUM_W  = PR_W + 17;

  // pipelined divider: four quotient bits per stage
  localparam int DIV_BPS    = 4;
  localparam int DIV_NW     = ((NUM_W + DIV_BPS - 1) / DIV_BPS) * DIV_BPS;
  localparam int DIV_DW     = RADIUS_BITS + 1;
  localparam int DIV_STAGES = DIV_NW / DIV_BPS;

  // pipelined square root: one root bit per stage
  localparam int SQ_RW    = 64;
  localparam int SQ_NW    = 2 * SQ_RW;
  localparam int SQ_REMW  = SQ_RW + 3;

  localparam int SPD_W  = 48;
  localparam int HALF_W = SPD_W / 2;

  // CORDIC datapath
  localparam int CX_W = 34;
  localparam int CZ_W = 33;
  localparam logic signed [CX_W-1:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [CX_W-1:0] Q30_ONE   = 34'sd1073741824;
  localparam logic [31:0] ATAN_TURN [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  localparam logic ERR_OK          = 1'b0;
  localparam logic ERR_ZERO_RADIUS = 1'b1;

  // round half up at fraction bit f, saturate to 32 bits
  function automatic logic [OUT_W-1:0] round_sat(input logic [63:0] x, input int unsigned f);
    logic [63:0] r;
    r = (x >> f) + ((x >> (f - 1)) & 64'd1);
    return (r > 64'hFFFF_FFFF) ? {OUT_W{1'b1}} : r[OUT_W-1:0];
  endfunction

endpackage

[src/hohmann_transfer_delta_v.sv]
// ----------------------------------------------------------------------------
// hohmann_transfer_delta_v
// Hohmann burns and combined plane-change burn for two circular orbits.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid/item_stall) carries two radii in km and a plane
//   change angle; a beat is taken when item_valid is high and item_stall low.
//   Result channel (result_valid/result_stall) carries the three burns in
//   mm/s and an error code; a zero radius gives code 1 and zero burns.
//   grav_param_q8 is written over cfg_valid/cfg_ready (always ready); write
//   it only while no item is in flight.
//   The depth is set by two chained dividers of 29 stages and two chained
//   square roots of 64 stages, one root bit a stage. Throughput is one item
//   per cycle while no result is held by result_stall.
//   The whole pipeline moves on one enable; while a result is held by
//   result_stall every stage holds and item_stall is raised, so nothing is
//   lost or repeated. Bubbles are not squeezed out.
//   Reset clears all valid bits and loads the Earth value into the register.
// ----------------------------------------------------------------------------
`include "hohmann_transfer_delta_v_macros.svh"

module hohmann_transfer_delta_v import htdv_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [MU_W-1:0]              grav_param_q8,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic [RADIUS_BITS-1:0]       radius_start_km,
  input  logic [RADIUS_BITS-1:0]       radius_end_km,
  input  logic signed [ANGLE_BITS-1:0] incl_change,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [OUT_W-1:0]             burn_one_mm_s,
  output logic [OUT_W-1:0]             burn_two_mm_s,
  output logic [OUT_W-1:0]             combined_total_mm_s,
  output logic                         error_code
);

  localparam int LD      = DIV_STAGES;
  localparam int LS      = SQ_RW;
  localparam int LC      = CORDIC_STEPS + 2;
  localparam int OUT_IDX = 11 + 2 * LD + 2 * LS;
  localparam int OMC_DLY = 7 + 2 * LD + LS - LC;
  localparam int DV_DLY  = 4 + LS;
  localparam int ERR_DLY = 9 + 2 * LD + 2 * LS;

  logic [MU_W-1:0] mu;
  logic [OUT_IDX:0] vld;
  logic adv;

  assign adv        = !(vld[OUT_IDX] && result_stall);
  assign item_stall = !adv;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mu <= MU_RESET;
    end else if (cfg_valid) begin
      mu <= grav_param_q8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[OUT_IDX-1:0], item_valid};
    end
  end

  // ---- capture, mu * 5^12, products with the radii ----
  logic [RADIUS_BITS-1:0] r1_a, r2_a, r1_b, r2_b, r1_c, r2_c, r1_d, r2_d;
  logic [ANGLE_BITS-1:0]  ang_a;
  logic                   err_a;
  logic [51:0]            mlo_b, mhi_b;
  logic [BM_W-1:0]        bm_c, bm_d;
  logic [PP_W-1:0]        pa0_d, pa1_d, pa2_d, pb0_d, pb1_d, pb2_d;
  logic [DIV_DW-1:0]      s_d, s_e, r1_e, r2_e;
  logic [PR_W-1:0]        pr1, pr2;
  logic [DIV_NW-1:0]      base_e, nump_e, numa_e;

  always_ff @(posedge clk) begin
    if (adv) begin
      r1_a  <= radius_start_km;
      r2_a  <= radius_end_km;
      ang_a <= incl_change;
      err_a <= (radius_start_km == '0) || (radius_end_km == '0);

      mlo_b <= 52'(mu[23:0]) * 52'(FIVE_POW_12);
      mhi_b <= 52'(mu[47:24]) * 52'(FIVE_POW_12);
      r1_b  <= r1_a;
      r2_b  <= r2_a;

      bm_c <= (BM_W'(mhi_b) << 24) + BM_W'(mlo_b);
      r1_c <= r1_b;
      r2_c <= r2_b;

      pa0_d <= PP_W'(bm_c[25:0]) * PP_W'(r1_c);
      pa1_d <= PP_W'(bm_c[51:26]) * PP_W'(r1_c);
      pa2_d <= PP_W'(bm_c[75:52]) * PP_W'(r1_c);
      pb0_d <= PP_W'(bm_c[25:0]) * PP_W'(r2_c);
      pb1_d <= PP_W'(bm_c[51:26]) * PP_W'(r2_c);
      pb2_d <= PP_W'(bm_c[75:52]) * PP_W'(r2_c);
      bm_d  <= bm_c;
      r1_d  <= r1_c;
      r2_d  <= r2_c;
      s_d   <= DIV_DW'(r1_c) + DIV_DW'(r2_c);

      base_e <= DIV_NW'({bm_d, 16'd0});
      nump_e <= DIV_NW'({pr2, 17'd0});
      numa_e <= DIV_NW'({pr1, 17'd0});
      r1_e   <= DIV_DW'(r1_d);
      r2_e   <= DIV_DW'(r2_d);
      s_e    <= s_d;
    end
  end

  assign pr1 = (PR_W'(pa2_d) << 52) + (PR_W'(pa1_d) << 26) + PR_W'(pa0_d);
  assign pr2 = (PR_W'(pb2_d) << 52) + (PR_W'(pb1_d) << 26) + PR_W'(pb0_d);

  // ---- squared speeds ----
  logic [DIV_NW-1:0] q_c1, q_c2, q_p, q_a, psq, asq;
  logic [DIV_DW-1:0] s_dl  [LD];
  logic [DIV_NW-1:0] c1_dl [LD];
  logic [DIV_NW-1:0] c2_dl [LD];

  htdv_div u_div_c1 (.clk(clk), .adv(adv), .num(base_e), .den(r1_e), .quo(q_c1));
  htdv_div u_div_c2 (.clk(clk), .adv(adv), .num(base_e), .den(r2_e), .quo(q_c2));
  htdv_div u_div_p1 (.clk(clk), .adv(adv), .num(nump_e), .den(r1_e), .quo(q_p));
  htdv_div u_div_a1 (.clk(clk), .adv(adv), .num(numa_e), .den(r2_e), .quo(q_a));

  always_ff @(posedge clk) begin
    if (adv) begin
      s_dl[0]  <= s_e;
      c1_dl[0] <= q_c1;
      c2_dl[0] <= q_c2;
      for (int i = 1; i < LD; i++) begin
        s_dl[i]  <= s_dl[i-1];
        c1_dl[i] <= c1_dl[i-1];
        c2_dl[i] <= c2_dl[i-1];
      end
    end
  end

  htdv_div u_div_p2 (.clk(clk), .adv(adv), .num(q_p), .den(s_dl[LD-1]), .quo(psq));
  htdv_div u_div_a2 (.clk(clk), .adv(adv), .num(q_a), .den(s_dl[LD-1]), .quo(asq));

  // ---- speeds ----
  logic [SQ_RW-1:0] rt_c1, rt_c2, rt_p, rt_a;

  htdv_sqrt u_sqrt_c1 (.clk(clk), .adv(adv), .num(SQ_NW'(c1_dl[LD-1])), .root(rt_c1));
  htdv_sqrt u_sqrt_c2 (.clk(clk), .adv(adv), .num(SQ_NW'(c2_dl[LD-1])), .root(rt_c2));
  htdv_sqrt u_sqrt_p  (.clk(clk), .adv(adv), .num(SQ_NW'(psq)), .root(rt_p));
  htdv_sqrt u_sqrt_a  (.clk(clk), .adv(adv), .num(SQ_NW'(asq)), .root(rt_a));

  // ---- cosine of the plane change ----
  logic [ANGLE_BITS:0]     mag;
  logic [31:0]             turn, turn_f;
  logic                    fold_neg;
  logic signed [CX_W-1:0]  cx [CORDIC_STEPS+1];
  logic signed [CX_W-1:0]  cy [CORDIC_STEPS+1];
  logic signed [CZ_W-1:0]  cz [CORDIC_STEPS+1];
  logic                    cneg [CORDIC_STEPS+1];
  logic signed [CX_W-1:0]  xf, cc, omc_w;
  logic [31:0]             omc_c;
  logic [31:0]             omc_dl [OMC_DLY];

  always_comb begin
    mag = ang_a[ANGLE_BITS-1] ? ({1'b1, {ANGLE_BITS{1'b0}}} - {1'b0, ang_a})
                              : {1'b0, ang_a};
    turn     = 32'(mag) << (32 - ANGLE_BITS);
    turn_f   = turn;
    fold_neg = 1'b0;
    // beyond a quarter turn: use the supplement and negate
    if (turn > 32'h4000_0000) begin
      turn_f   = 32'h8000_0000 - turn;
      fold_neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx[0]   <= CORDIC_X0;
      cy[0]   <= '0;
      cz[0]   <= $signed({1'b0, turn_f});
      cneg[0] <= fold_neg;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    logic signed [CX_W-1:0] xs, ys;
    logic signed [CZ_W-1:0] at;
    assign xs = cx[k] >>> k;
    assign ys = cy[k] >>> k;
    assign at = $signed({1'b0, ATAN_TURN[k]});

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!cz[k][CZ_W-1]) begin
          cx[k+1] <= cx[k] - ys;
          cy[k+1] <= cy[k] + xs;
          cz[k+1] <= cz[k] - at;
        end else begin
          cx[k+1] <= cx[k] + ys;
          cy[k+1] <= cy[k] - xs;
          cz[k+1] <= cz[k] + at;
        end
        cneg[k+1] <= cneg[k];
      end
    end
  end

  always_comb begin
    xf = cneg[CORDIC_STEPS] ? -cx[CORDIC_STEPS] : cx[CORDIC_STEPS];
    cc = xf;
    if (xf > Q30_ONE) cc = Q30_ONE;
    if (xf < -Q30_ONE) cc = -Q30_ONE;
    omc_w = Q30_ONE - cc;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      omc_c     <= omc_w[31:0];
      omc_dl[0] <= omc_c;
      for (int i = 1; i < OMC_DLY; i++) begin
        omc_dl[i] <= omc_dl[i-1];
      end
    end
  end

  // ---- burns and the combined burn ----
  logic [SPD_W-1:0]   vc1, vc2, vp, va;
  logic [SPD_W-1:0]   dv1_p, dv2_p, va_p, vc2_p;
  logic [2*HALF_W-1:0] sq_hh, sq_hl, sq_ll, m_hh, m_hl, m_lh, m_ll;
  logic [2*SPD_W-1:0] sqd_3, m_3, sqd_4;
  logic [63:0]        q0_4, q1_4, q2_4;
  logic [SQ_NW-1:0]   prod, sq_5;
  logic [SQ_RW-1:0]   comb;
  logic [2*SPD_W-1:0] dv_dl [DV_DLY];
  logic               err_dl [ERR_DLY];
  logic [SPD_W-1:0]   dv1_z, dv2_z;

  assign vc1 = rt_c1[SPD_W-1:0];
  assign vc2 = rt_c2[SPD_W-1:0];
  assign vp  = rt_p[SPD_W-1:0];
  assign va  = rt_a[SPD_W-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      dv1_p <= (vp > vc1) ? (vp - vc1) : (vc1 - vp);
      dv2_p <= (vc2 > va) ? (vc2 - va) : (va - vc2);
      va_p  <= va;
      vc2_p <= vc2;

      sq_hh <= (2*HALF_W)'(dv2_p[SPD_W-1:HALF_W]) * (2*HALF_W)'(dv2_p[SPD_W-1:HALF_W]);
      sq_hl <= (2*HALF_W)'(dv2_p[SPD_W-1:HALF_W]) * (2*HALF_W)'(dv2_p[HALF_W-1:0]);
      sq_ll <= (2*HALF_W)'(dv2_p[HALF_W-1:0]) * (2*HALF_W)'(dv2_p[HALF_W-1:0]);
      m_hh  <= (2*HALF_W)'(va_p[SPD_W-1:HALF_W]) * (2*HALF_W)'(vc2_p[SPD_W-1:HALF_W]);
      m_hl  <= (2*HALF_W)'(va_p[SPD_W-1:HALF_W]) * (2*HALF_W)'(vc2_p[HALF_W-1:0]);
      m_lh  <= (2*HALF_W)'(va_p[HALF_W-1:0]) * (2*HALF_W)'(vc2_p[SPD_W-1:HALF_W]);
      m_ll  <= (2*HALF_W)'(va_p[HALF_W-1:0]) * (2*HALF_W)'(vc2_p[HALF_W-1:0]);

      sqd_3 <= ((2*SPD_W)'(sq_hh) << SPD_W) + ((2*SPD_W)'(sq_hl) << (HALF_W + 1))
             + (2*SPD_W)'(sq_ll);
      m_3   <= ((2*SPD_W)'(m_hh) << SPD_W) + ((2*SPD_W)'(m_hl) << HALF_W)
             + ((2*SPD_W)'(m_lh) << HALF_W) + (2*SPD_W)'(m_ll);

      q0_4  <= 64'(m_3[31:0]) * 64'(omc_dl[OMC_DLY-1]);
      q1_4  <= 64'(m_3[63:32]) * 64'(omc_dl[OMC_DLY-1]);
      q2_4  <= 64'(m_3[95:64]) * 64'(omc_dl[OMC_DLY-1]);
      sqd_4 <= sqd_3;

      sq_5 <= (prod << 1) + (SQ_NW'(sqd_4) << 30);
    end
  end

  assign prod = (SQ_NW'(q2_4) << 64) + (SQ_NW'(q1_4) << 32) + SQ_NW'(q0_4);

  htdv_sqrt u_sqrt_comb (.clk(clk), .adv(adv), .num(sq_5), .root(comb));

  // hold the burns and the error flag alongside the last root
  always_ff @(posedge clk) begin
    if (adv) begin
      dv_dl[0]  <= {dv1_p, dv2_p};
      err_dl[0] <= err_a;
      for (int i = 1; i < DV_DLY; i++) begin
        dv_dl[i] <= dv_dl[i-1];
      end
      for (int i = 1; i < ERR_DLY; i++) begin
        err_dl[i] <= err_dl[i-1];
      end
    end
  end

  assign dv1_z = dv_dl[DV_DLY-1][2*SPD_W-1:SPD_W];
  assign dv2_z = dv_dl[DV_DLY-1][SPD_W-1:0];

  // ---- rounding and output register ----
  logic [OUT_W-1:0] b1_r, b2_r, cr_r;
  logic             err_r;
  logic [OUT_W:0]   tot;
  logic [OUT_W-1:0] b1_q, b2_q, tot_q;
  logic             err_q;

  assign tot = (OUT_W+1)'(b1_r) + (OUT_W+1)'(cr_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_r  <= round_sat(64'(dv1_z), 6);
      b2_r  <= round_sat(64'(dv2_z), 6);
      cr_r  <= round_sat(comb, 21);
      err_r <= err_dl[ERR_DLY-1];

      if (err_r) begin
        b1_q  <= '0;
        b2_q  <= '0;
        tot_q <= '0;
        err_q <= ERR_ZERO_RADIUS;
      end else begin
        b1_q  <= b1_r;
        b2_q  <= b2_r;
        tot_q <= tot[OUT_W] ? {OUT_W{1'b1}} : tot[OUT_W-1:0];
        err_q <= ERR_OK;
      end
    end
  end

  assign result_valid        = vld[OUT_IDX];
  assign burn_one_mm_s       = b1_q;
  assign burn_two_mm_s       = b2_q;
  assign combined_total_mm_s = tot_q;
  assign error_code          = err_q;

  // ---- checks ----
  `HTDV_ASSERT_IMPLIES(a_err_zeroes, clk, rst, result_valid && (error_code == ERR_ZERO_RADIUS), (burn_one_mm_s == '0) && (burn_two_mm_s == '0) && (combined_total_mm_s == '0))
  `HTDV_ASSERT_IMPLIES(a_total_covers_one, clk, rst, result_valid, combined_total_mm_s >= burn_one_mm_s)
  `HTDV_ASSERT_NEXT(a_stall_freezes_pipe, clk, rst, item_stall, $stable(vld))
  `HTDV_ASSERT_IMPLIES(a_stall_from_output, clk, rst, item_stall, result_valid && result_stall)

endmodule

[src/htdv_div.sv]
// ----------------------------------------------------------------------------
// htdv_div
// Pipelined restoring divider, floor quotient, four quotient bits per stage.
// ----------------------------------------------------------------------------
module htdv_div import htdv_pkg::*; (
  input  logic              clk,
  input  logic              adv,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic [DIV_NW-1:0] quo
);

  logic [DIV_DW-1:0] rem_q [DIV_STAGES];
  logic [DIV_NW-1:0] nq_q  [DIV_STAGES];
  logic [DIV_DW-1:0] den_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [DIV_DW-1:0] rem_in, den_in, rem_next;
    logic [DIV_NW-1:0] nq_in, nq_next;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num;
      assign den_in = den;
    end else begin : g_later
      assign rem_in = rem_q[k-1];
      assign nq_in  = nq_q[k-1];
      assign den_in = den_q[k-1];
    end

    // shift numerator bits out of the top, quotient bits in at the bottom
    always_comb begin
      logic [DIV_DW:0] t;
      rem_next = rem_in;
      nq_next  = nq_in;
      for (int j = 0; j < DIV_BPS; j++) begin
        t = {rem_next, nq_next[DIV_NW-1]};
        nq_next = {nq_next[DIV_NW-2:0], 1'b0};
        if (t >= {1'b0, den_in}) begin
          t = t - {1'b0, den_in};
          nq_next[0] = 1'b1;
        end
        rem_next = t[DIV_DW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_q[k] <= rem_next;
        nq_q[k]  <= nq_next;
        den_q[k] <= den_in;
      end
    end
  end

  assign quo = nq_q[DIV_STAGES-1];

endmodule

[src/htdv_sqrt.sv]
// ----------------------------------------------------------------------------
// htdv_sqrt
// Pipelined digit-by-digit floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
module htdv_sqrt import htdv_pkg::*; (
  input  logic             clk,
  input  logic             adv,
  input  logic [SQ_NW-1:0] num,
  output logic [SQ_RW-1:0] root
);

  logic [SQ_REMW-1:0] rem_q  [SQ_RW];
  logic [SQ_RW-1:0]   root_q [SQ_RW];
  logic [SQ_NW-1:0]   n_q    [SQ_RW];

  for (genvar k = 0; k < SQ_RW; k++) begin : g_stage
    logic [SQ_REMW-1:0] rem_in, rem_next, t, trial;
    logic [SQ_RW-1:0]   root_in, root_next;
    logic [SQ_NW-1:0]   n_in;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = num;
    end else begin : g_later
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign n_in    = n_q[k-1];
    end

    // bring down two bits, try root*4+1
    assign t     = {rem_in[SQ_REMW-3:0], n_in[SQ_NW-1:SQ_NW-2]};
    assign trial = SQ_REMW'({root_in, 2'b01});

    always_comb begin
      if (t >= trial) begin
        rem_next  = t - trial;
        root_next = {root_in[SQ_RW-2:0], 1'b1};
      end else begin
        rem_next  = t;
        root_next = {root_in[SQ_RW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_q[k]  <= rem_next;
        root_q[k] <= root_next;
        n_q[k]    <= {n_in[SQ_NW-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[SQ_RW-1];

endmodule

[tb/sv/hohmann_transfer_delta_v_tb.sv]
// ----------------------------------------------------------------------------
// Hohmann transfer delta-v testbench
// Drives orbit pairs and plane change angles through the pipeline under
// random idling and back-pressure, and checks every result beat against an
// exact integer predictor, across several gravitational parameter settings.
// ----------------------------------------------------------------------------
module hohmann_transfer_delta_v_tb import htdv_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 300;
  localparam int RANDOM_ITEMS = 1530;

  typedef struct packed {
    logic [OUT_W-1:0] burn_one;
    logic [OUT_W-1:0] burn_two;
    logic [OUT_W-1:0] total;
    logic             err;
  } burns_t;

  typedef struct {
    logic [RADIUS_BITS-1:0]       r1;
    logic [RADIUS_BITS-1:0]       r2;
    logic signed [ANGLE_BITS-1:0] ang;
    bit                           typed;
    burns_t                       known;
  } row_t;

  logic                         clk;
  logic                         rst;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [MU_W-1:0]              grav_param_q8;
  logic                         item_valid;
  logic                         item_stall;
  logic [RADIUS_BITS-1:0]       radius_start_km;
  logic [RADIUS_BITS-1:0]       radius_end_km;
  logic signed [ANGLE_BITS-1:0] incl_change;
  logic                         result_valid;
  logic                         result_stall;
  logic [OUT_W-1:0]             burn_one_mm_s;
  logic [OUT_W-1:0]             burn_two_mm_s;
  logic [OUT_W-1:0]             combined_total_mm_s;
  logic                         error_code;

  logic [MU_W-1:0] mu_now;
  burns_t          burn_q[$];
  int              fail_count;
  int              cycles;
  int              beats_in;
  int              beats_out;
  int              zero_radius_seen;
  bit              calm;

  hohmann_transfer_delta_v dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .grav_param_q8       (grav_param_q8),
    .item_valid          (item_valid),
    .item_stall          (item_stall),
    .radius_start_km     (radius_start_km),
    .radius_end_km       (radius_end_km),
    .incl_change         (incl_change),
    .result_valid        (result_valid),
    .result_stall        (result_stall),
    .burn_one_mm_s       (burn_one_mm_s),
    .burn_two_mm_s       (burn_two_mm_s),
    .combined_total_mm_s (combined_total_mm_s),
    .error_code          (error_code)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("hohmann_transfer_delta_v_tb failed");
      $finish;
    end
  end

  // floor square root of a 128-bit value
  function automatic logic [63:0] root128(input logic [127:0] n);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] cw;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      cw = c;
      if (cw * cw <= n) r = c;
    end
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] to_mm_s(input logic [63:0] x, input int f);
    logic [63:0] r;
    r = (x >> f) + ((x >> (f - 1)) & 64'd1);
    return (r > 64'hFFFF_FFFF) ? {OUT_W{1'b1}} : r[OUT_W-1:0];
  endfunction

  // Q30 cosine; fold the angle into the first quadrant, flip sign after
  function automatic longint cos_q30(input logic signed [ANGLE_BITS-1:0] a);
    logic [ANGLE_BITS-1:0] raw;
    longint unsigned       mag;
    longint unsigned       turn;
    longint                x;
    longint                y;
    longint                z;
    longint                xs;
    longint                ys;
    bit                    neg;
    raw = a;
    neg = 1'b0;
    mag = raw[ANGLE_BITS-1] ? ((64'd1 << ANGLE_BITS) - raw) : raw;
    turn = mag << (32 - ANGLE_BITS);
    if (turn > (64'd1 << 30)) begin
      turn = (64'd1 << 31) - turn;
      neg = 1'b1;
    end
    z = turn;
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - longint'(ATAN_TURN[i]);
      end else begin
        x = x + ys; y = y - xs; z = z + longint'(ATAN_TURN[i]);
      end
    end
    if (neg) x = -x;
    if (x > 64'sd1073741824) x = 64'sd1073741824;
    if (x < -64'sd1073741824) x = -64'sd1073741824;
    return x;
  endfunction

  function automatic burns_t calc_burns(input logic [RADIUS_BITS-1:0] a1,
                                        input logic [RADIUS_BITS-1:0] a2,
                                        input logic signed [ANGLE_BITS-1:0] ang);
    burns_t       o;
    logic [127:0] r1;
    logic [127:0] r2;
    logic [127:0] s;
    logic [127:0] base;
    logic [127:0] w;
    logic [127:0] sq;
    logic [63:0]  vc1;
    logic [63:0]  vc2;
    logic [63:0]  vp;
    logic [63:0]  va;
    logic [63:0]  dv1;
    logic [63:0]  dv2;
    logic [63:0]  comb;
    logic [63:0]  omc;
    logic [32:0]  t;
    o = '0;
    if (a1 == 0 || a2 == 0) begin
      o.err = ERR_ZERO_RADIUS;
      return o;
    end
    r1 = a1;
    r2 = a2;
    s = r1 + r2;
    base = (128'(mu_now) * 128'd244140625) << 16;
    vc1 = root128(base / r1);
    vc2 = root128(base / r2);
    vp = root128(((base * (r2 << 1)) / r1) / s);
    va = root128(((base * (r1 << 1)) / r2) / s);
    dv1 = (vp > vc1) ? vp - vc1 : vc1 - vp;
    dv2 = (vc2 > va) ? vc2 - va : va - vc2;
    omc = 64'(64'sd1073741824 - cos_q30(ang));
    w = dv2;
    sq = (w * w) << 30;
    w = va;
    sq = sq + (w * 128'(vc2)) * (128'(omc) << 1);
    comb = root128(sq);
    o.burn_one = to_mm_s(dv1, 6);
    o.burn_two = to_mm_s(dv2, 6);
    t = {1'b0, o.burn_one} + {1'b0, to_mm_s(comb, 21)};
    o.total = t[32] ? {OUT_W{1'b1}} : t[OUT_W-1:0];
    o.err = ERR_OK;
    return o;
  endfunction

  // result side: check at the edge, then pick the next stall
  always @(posedge clk) begin
    burns_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        beats_out <= beats_out + 1;
        if (burn_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          want = burn_q.pop_front();
          if (burn_one_mm_s !== want.burn_one) begin
            $error("burn_one_mm_s expected %0d got %0d", want.burn_one, burn_one_mm_s);
            fail_count++;
          end
          if (burn_two_mm_s !== want.burn_two) begin
            $error("burn_two_mm_s expected %0d got %0d", want.burn_two, burn_two_mm_s);
            fail_count++;
          end
          if (combined_total_mm_s !== want.total) begin
            $error("combined_total_mm_s expected %0d got %0d", want.total,
                   combined_total_mm_s);
            fail_count++;
          end
          if (error_code !== want.err) begin
            $error("error_code expected %0d got %0d", want.err, error_code);
            fail_count++;
          end
        end
      end
      result_stall <= !calm && ($urandom_range(99) < 17);
    end
  end

  // call at a clock edge; returns at the edge where the beat is taken
  task automatic send_item(input logic [RADIUS_BITS-1:0] r1,
                           input logic [RADIUS_BITS-1:0] r2,
                           input logic signed [ANGLE_BITS-1:0] ang,
                           input bit typed, input burns_t known);
    burns_t want;
    item_valid <= 1'b1;
    radius_start_km <= r1;
    radius_end_km <= r2;
    incl_change <= ang;
    do @(posedge clk); while (item_stall);
    want = calc_burns(r1, r2, ang);
    if (typed && want !== known) begin
      $error("predictor disagrees with typed row %0d %0d %0d", r1, r2, ang);
      fail_count++;
    end
    burn_q = {burn_q, (typed ? known : want)};
    beats_in++;
    if (r1 == 0 || r2 == 0) zero_radius_seen++;
  endtask

  task automatic idle_gap();
    if (!calm) begin
      while ($urandom_range(99) < 17) begin
        item_valid <= 1'b0;
        radius_start_km <= RADIUS_BITS'($urandom);
        @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (burn_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_mu(input logic [MU_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    grav_param_q8 <= v;
    do @(posedge clk); while (!cfg_ready);
    mu_now = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [RADIUS_BITS-1:0] pick_radius();
    int sel;
    sel = $urandom_range(99);
    if (sel < 2) return '0;
    if (sel < 12) return RADIUS_BITS'($urandom_range(100, 1));
    if (sel < 30) return RADIUS_BITS'($urandom);
    return RADIUS_BITS'($urandom_range(500000, 6400));
  endfunction

  row_t   rows[$];
  burns_t zeros_err;
  burns_t none;
  logic [MU_W-1:0] mu_set[5];

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    grav_param_q8 = '0;
    item_valid = 1'b0;
    radius_start_km = '0;
    radius_end_km = '0;
    incl_change = '0;
    result_stall = 1'b0;
    fail_count = 0;
    cycles = 0;
    beats_in = 0;
    beats_out = 0;
    zero_radius_seen = 0;
    calm = 1'b0;
    mu_now = MU_RESET;
    zeros_err = '0;
    zeros_err.err = ERR_ZERO_RADIUS;
    none = '0;

    // zero radius rows are typed; the rest go through the predictor
    rows = '{
      '{20'd0, 20'd42164, 16'sd0, 1'b1, zeros_err},
      '{20'd6678, 20'd0, 16'sd1000, 1'b1, zeros_err},
      '{20'd0, 20'd0, -16'sd32768, 1'b1, zeros_err},
      '{20'd6678, 20'd42164, 16'sd0, 1'b0, none},
      '{20'd6678, 20'd42164, 16'sd5006, 1'b0, none},
      '{20'd42164, 20'd6678, -16'sd5006, 1'b0, none},
      '{20'd7000, 20'd7000, 16'sd0, 1'b0, none},
      '{20'd7000, 20'd7000, 16'sd16384, 1'b0, none},
      '{20'd1, 20'd1, 16'sd32767, 1'b0, none},
      '{20'd1, 20'hFFFFF, 16'sd0, 1'b0, none},
      '{20'hFFFFF, 20'd1, -16'sd32768, 1'b0, none},
      '{20'hFFFFF, 20'hFFFFF, -16'sd1, 1'b0, none},
      '{20'd6678, 20'd384400, 16'sd16383, 1'b0, none},
      '{20'd6678, 20'd384400, -16'sd16385, 1'b0, none},
      '{20'd26560, 20'd42164, 16'sd1, 1'b0, none},
      '{20'd12345, 20'd678901, 16'sd21845, 1'b0, none},
      '{20'h55555, 20'hAAAAA, 16'sh5555, 1'b0, none},
      '{20'hAAAAA, 20'h55555, -16'sh5556, 1'b0, none},
      '{20'd2, 20'd3, 16'sd8192, 1'b0, none}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      send_item(rows[i].r1, rows[i].r2, rows[i].ang, rows[i].typed, rows[i].known);
      idle_gap();
    end

    // extremes of mu first, then a random value, then ordinary bodies
    mu_set[0] = {MU_W{1'b1}};
    mu_set[1] = 48'd1;
    mu_set[2] = MU_W'({$urandom, $urandom});
    mu_set[3] = 48'd33982624112640;
    mu_set[4] = MU_RESET;
    for (int p = 0; p < 5; p++) begin
      write_mu(mu_set[p]);
      for (int k = 0; k < RANDOM_ITEMS / 5; k++) begin
        calm = (p == 3) && (k >= 50) && (k < 250);
        send_item(pick_radius(), pick_radius(), ANGLE_BITS'($urandom), 1'b0, none);
        if (k == 120) drain();
        idle_gap();
      end
      calm = 1'b0;
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run: %0d items in, %0d results out, %0d with a zero radius",
             beats_in, beats_out, zero_radius_seen);
    $display("run: directed table at reset mu, then %0d written mu values", 5);
    if (fail_count == 0 && burn_q.size() == 0) begin
      $display("hohmann_transfer_delta_v_tb passed");
    end else begin
      $display("hohmann_transfer_delta_v_tb failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/htdv_pkg.sv
src/htdv_div.sv
src/htdv_sqrt.sv
src/hohmann_transfer_delta_v.sv
tb/sv/hohmann_transfer_delta_v_tb.sv
